// ===== rtl/core/cubic_hermite_interpolator_defines.svh =====
// Assertion macros shared by the interpolator RTL.
// Expects clk and rst to be visible in the including module.
`ifndef CUBIC_HERMITE_INTERPOLATOR_DEFINES_SVH
`define CUBIC_HERMITE_INTERPOLATOR_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define CHI_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define CHI_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/chi_pkg.sv =====
// Shared types, constants and saturating arithmetic for the interpolator.
// No dependencies.
`timescale 1ns / 1ps

package chi_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ACC_W          = 64;
  localparam int DIV_STEP       = 4;
  localparam int MUL_LAT        = 4;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic sat;
    acc_t val;
  } sres_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SPAN_ZERO = 2'd1,
    STATUS_SAT       = 2'd2
  } status_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  function automatic sres_t sadd(input acc_t a, input acc_t b);
    acc_t  s;
    sres_t r;
    s     = a + b;
    r.sat = (a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
    r.val = r.sat ? (a[ACC_W-1] ? ACC_MIN : ACC_MAX) : s;
    return r;
  endfunction

  function automatic sres_t ssub(input acc_t a, input acc_t b);
    acc_t  s;
    sres_t r;
    s     = a - b;
    r.sat = (a[ACC_W-1] != b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
    r.val = r.sat ? (a[ACC_W-1] ? ACC_MIN : ACC_MAX) : s;
    return r;
  endfunction

  function automatic logic [ACC_W-1:0] magnitude(input acc_t v);
    logic [ACC_W-1:0] u;
    u = v;
    return v[ACC_W-1] ? (~u + 1'b1) : u;
  endfunction

  // Apply sign to a magnitude; big flags bits above the 64-bit magnitude.
  function automatic sres_t signed_clip(input logic neg, input logic big,
                                        input logic [ACC_W-1:0] mag);
    logic  ovf;
    sres_t r;
    ovf   = big || (neg ? (mag[ACC_W-1] && (|mag[ACC_W-2:0])) : mag[ACC_W-1]);
    r.sat = ovf;
    r.val = ovf ? (neg ? ACC_MIN : ACC_MAX) : (neg ? acc_t'(~mag + 1'b1) : acc_t'(mag));
    return r;
  endfunction

endpackage

// ===== rtl/core/chi_ifs.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on chi_pkg for default widths.
`timescale 1ns / 1ps

interface chi_request_if #(parameter int DATA_WIDTH = chi_pkg::DATA_WIDTH_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value_start;
  logic signed [DATA_WIDTH-1:0] slope_start;
  logic signed [DATA_WIDTH-1:0] value_end;
  logic signed [DATA_WIDTH-1:0] slope_end;
  logic        [DATA_WIDTH-2:0] span;
  logic signed [DATA_WIDTH-1:0] position;

  modport source (output valid, value_start, slope_start, value_end, slope_end, span,
                  position, input ready);
  modport sink   (input valid, value_start, slope_start, value_end, slope_end, span,
                  position, output ready);
endinterface

interface chi_result_if #(parameter int DATA_WIDTH = chi_pkg::DATA_WIDTH_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] interp_value;
  logic signed [DATA_WIDTH-1:0] interp_slope;
  logic signed [DATA_WIDTH-1:0] interp_curvature;
  logic        [1:0]            status;

  modport source (output valid, interp_value, interp_slope, interp_curvature, status,
                  input ready);
  modport sink   (input valid, interp_value, interp_slope, interp_curvature, status,
                  output ready);
endinterface

// ===== rtl/core/chi_delay.sv =====
// Enabled shift line that keeps side data aligned with a pipelined unit.
// No dependencies.
`timescale 1ns / 1ps

module chi_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] pipe [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        pipe[i] <= pipe[i-1];
      end
    end
  end

  assign dout = pipe[DEPTH-1];

endmodule

// ===== rtl/core/chi_div.sv =====
// Pipelined restoring divider: (num << FRAC_BITS) / den, truncated, saturated.
// Depends on chi_pkg.
`timescale 1ns / 1ps

module chi_div #(
  parameter int SPAN_W    = chi_pkg::DATA_WIDTH_DEF - 1,
  parameter int FRAC_BITS = chi_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  chi_pkg::acc_t      num,
  input  logic [SPAN_W-1:0]  den,
  output logic               out_valid,
  output chi_pkg::acc_t      quo,
  output logic               sat
);

  localparam int STEP = chi_pkg::DIV_STEP;
  localparam int QW   = chi_pkg::ACC_W + FRAC_BITS;
  localparam int NS   = (QW + STEP - 1) / STEP;
  localparam int PW   = NS * STEP;

  logic              valid_s [NS+1];
  logic              neg_s   [NS+1];
  logic [SPAN_W-1:0] den_s   [NS+1];
  logic [SPAN_W-1:0] rem_s   [NS+1];
  logic [PW-1:0]     dq_s    [NS+1];

  logic [SPAN_W-1:0] rem_next [NS];
  logic [PW-1:0]     dq_next  [NS];

  logic [SPAN_W-1:0] r;
  logic [SPAN_W:0]   r2;
  logic [PW-1:0]     dq;

  chi_pkg::sres_t    clip;

  // Each stage retires STEP quotient bits; dq shifts dividend out, quotient in.
  always_comb begin
    r  = '0;
    r2 = '0;
    dq = '0;
    for (int s = 0; s < NS; s++) begin
      r  = rem_s[s];
      dq = dq_s[s];
      for (int k = 0; k < STEP; k++) begin
        r2 = {r, dq[PW-1]};
        dq = {dq[PW-2:0], 1'b0};
        if (r2 >= {1'b0, den_s[s]}) begin
          r2    = r2 - {1'b0, den_s[s]};
          dq[0] = 1'b1;
        end
        r = r2[SPAN_W-1:0];
      end
      rem_next[s] = r;
      dq_next[s]  = dq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= NS; s++) begin
        valid_s[s] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      valid_s[0] <= in_valid;
      for (int s = 0; s < NS; s++) begin
        valid_s[s+1] <= valid_s[s];
      end
      out_valid <= valid_s[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_s[0] <= num[chi_pkg::ACC_W-1];
      den_s[0] <= den;
      rem_s[0] <= '0;
      dq_s[0]  <= PW'({chi_pkg::magnitude(num), {FRAC_BITS{1'b0}}});
      for (int s = 0; s < NS; s++) begin
        neg_s[s+1] <= neg_s[s];
        den_s[s+1] <= den_s[s];
        rem_s[s+1] <= rem_next[s];
        dq_s[s+1]  <= dq_next[s];
      end
      quo <= clip.val;
      sat <= clip.sat;
    end
  end

  assign clip = chi_pkg::signed_clip(neg_s[NS], |dq_s[NS][PW-1:chi_pkg::ACC_W],
                                     dq_s[NS][chi_pkg::ACC_W-1:0]);

endmodule

// ===== rtl/core/chi_muladd.sv =====
// Four-stage fixed-point multiply-add: sat(sat(lhs*rhs >> FRAC_BITS) + addend).
// Depends on chi_pkg.
`timescale 1ns / 1ps

module chi_muladd #(
  parameter int FRAC_BITS = chi_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  chi_pkg::acc_t lhs,
  input  chi_pkg::acc_t rhs,
  input  chi_pkg::acc_t addend,
  output logic          out_valid,
  output chi_pkg::acc_t res,
  output logic          sat
);

  localparam int W    = chi_pkg::ACC_W;
  localparam int HALF = W / 2;
  localparam int PROD = 2 * W;

  logic          v1, v2, v3;
  logic [W-1:0]  ma, mb;
  logic          neg1, neg2, neg3;
  chi_pkg::acc_t c1, c2, c3;
  logic [W-1:0]  p00, p01, p10, p11;
  logic [PROD-1:0] full, shifted;
  logic          big3;
  logic [W-1:0]  mag3;

  chi_pkg::sres_t clip, sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // Partial products of the magnitudes, then one wide sum.
  assign full    = {p11, p00} + ({{HALF{1'b0}}, p01, {HALF{1'b0}}})
                              + ({{HALF{1'b0}}, p10, {HALF{1'b0}}});
  assign shifted = full >> FRAC_BITS;
  assign clip    = chi_pkg::signed_clip(neg3, big3, mag3);
  assign sum     = chi_pkg::sadd(clip.val, c3);

  always_ff @(posedge clk) begin
    if (en) begin
      ma   <= chi_pkg::magnitude(lhs);
      mb   <= chi_pkg::magnitude(rhs);
      neg1 <= lhs[W-1] ^ rhs[W-1];
      c1   <= addend;

      p00  <= ma[HALF-1:0] * mb[HALF-1:0];
      p01  <= ma[HALF-1:0] * mb[W-1:HALF];
      p10  <= ma[W-1:HALF] * mb[HALF-1:0];
      p11  <= ma[W-1:HALF] * mb[W-1:HALF];
      neg2 <= neg1;
      c2   <= c1;

      big3 <= |shifted[PROD-1:W];
      mag3 <= shifted[W-1:0];
      neg3 <= neg2;
      c3   <= c2;

      res  <= sum.val;
      sat  <= clip.sat | sum.sat;
    end
  end

endmodule

// ===== rtl/core/cubic_hermite_interpolator.sv =====
// Cubic Hermite interpolator: value, slope and curvature at x, 64-bit saturating core.
// Throughput one request per cycle while results are taken; three chained dividers set the depth.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// rst (synchronous) clears valid bits only; data registers are not reset.
`timescale 1ns / 1ps
`include "cubic_hermite_interpolator_defines.svh"

module cubic_hermite_interpolator #(
  parameter int DATA_WIDTH = chi_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = chi_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  chi_request_if.sink   request,
  chi_result_if.source  result
);

  localparam int SPAN_W  = DATA_WIDTH - 1;
  localparam int DIV_LAT = (chi_pkg::ACC_W + FRAC_BITS + chi_pkg::DIV_STEP - 1)
                           / chi_pkg::DIV_STEP + 2;
  localparam int MUL_LAT = chi_pkg::MUL_LAT;

  typedef chi_pkg::acc_t  acc_t;
  typedef chi_pkg::sres_t sres_t;

  typedef struct packed {
    logic                  sat;
    logic [DATA_WIDTH-1:0] val;
  } oclip_t;

  // Side data carried past each long unit.
  typedef struct packed {
    acc_t sd; acc_t e; acc_t d0; acc_t f0; acc_t x;
    logic [SPAN_W-1:0] h; logic zero; logic sat;
  } side1_t;
  typedef struct packed {
    acc_t d0; acc_t f0; acc_t x; logic [SPAN_W-1:0] h; logic zero; logic sat;
  } side2_t;
  typedef struct packed {
    acc_t b; acc_t d0; acc_t f0; acc_t x; logic zero; logic sat;
  } side3_t;
  typedef struct packed {
    acc_t d0; acc_t f0; acc_t x; logic zero; logic sat;
  } side4_t;
  typedef struct packed {
    acc_t dd; acc_t f0; acc_t x; logic zero; logic sat;
  } side5_t;
  typedef struct packed {
    acc_t dy; acc_t dd; logic zero; logic sat;
  } side6_t;

  function automatic oclip_t clamp_out(input acc_t v);
    logic   ok;
    oclip_t r;
    ok    = (v[chi_pkg::ACC_W-1:DATA_WIDTH-1] == '0) ||
            (v[chi_pkg::ACC_W-1:DATA_WIDTH-1] == '1);
    r.sat = !ok;
    r.val = ok ? v[DATA_WIDTH-1:0]
               : (v[chi_pkg::ACC_W-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                      : {1'b0, {(DATA_WIDTH-1){1'b1}}});
    return r;
  endfunction

  // Global advance: the pipeline moves whenever the output slot can take a result.
  // Hold off requests while in reset so none is taken and then lost.
  logic advance;
  assign advance       = !result.valid || result.ready;
  assign request.ready = advance && !rst;

  // ---------------------------------------------------------------
  // Stage A: widen fields, first differences and slope sums.
  // ---------------------------------------------------------------
  acc_t f0_in, d0_in, f1_in, d1_in, x_in;
  sres_t su, suu, sd00, ssd;

  assign f0_in = 64'(request.value_start);
  assign d0_in = 64'(request.slope_start);
  assign f1_in = 64'(request.value_end);
  assign d1_in = 64'(request.slope_end);
  assign x_in  = 64'(request.position);
  assign su    = chi_pkg::ssub(f0_in, f1_in);
  assign suu   = chi_pkg::ssub(f1_in, f0_in);
  assign sd00  = chi_pkg::sadd(d0_in, d0_in);
  assign ssd   = chi_pkg::sadd(d0_in, d1_in);

  logic              va;
  acc_t              a_u, a_uu, a_d00, a_sd, a_d0, a_d1, a_f0, a_x;
  logic [SPAN_W-1:0] a_h;
  logic              a_zero, a_sat;

  always_ff @(posedge clk) begin
    if (advance) begin
      a_u    <= su.val;
      a_uu   <= suu.val;
      a_d00  <= sd00.val;
      a_sd   <= ssd.val;
      a_d0   <= d0_in;
      a_d1   <= d1_in;
      a_f0   <= f0_in;
      a_x    <= x_in;
      a_h    <= request.span;
      a_zero <= (request.span == '0);
      a_sat  <= su.sat | suu.sat | sd00.sat | ssd.sat;
    end
  end

  // ---------------------------------------------------------------
  // Stage B: numerators 2*(f0-f1) and 3*(f1-f0), and d1 + 2*d0.
  // ---------------------------------------------------------------
  sres_t sn1, sv2, sn3, se;
  assign sn1 = chi_pkg::sadd(a_u, a_u);
  assign sv2 = chi_pkg::sadd(a_uu, a_uu);
  assign sn3 = chi_pkg::sadd(sv2.val, a_uu);
  assign se  = chi_pkg::sadd(a_d1, a_d00);

  logic              vb;
  acc_t              b_num1, b_num3, b_sd, b_e, b_d0, b_f0, b_x;
  logic [SPAN_W-1:0] b_h;
  logic              b_zero, b_sat;

  always_ff @(posedge clk) begin
    if (advance) begin
      b_num1 <= sn1.val;
      b_num3 <= sn3.val;
      b_sd   <= a_sd;
      b_e    <= se.val;
      b_d0   <= a_d0;
      b_f0   <= a_f0;
      b_x    <= a_x;
      b_h    <= a_h;
      b_zero <= a_zero;
      b_sat  <= a_sat | sn1.sat | sv2.sat | sn3.sat | se.sat;
    end
  end

  // First division pair, run side by side.
  logic vq1, vq3, q1_sat, q3_sat;
  acc_t q1, q3;

  chi_div #(.SPAN_W(SPAN_W), .FRAC_BITS(FRAC_BITS)) u_div1 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(vb), .num(b_num1), .den(b_h),
    .out_valid(vq1), .quo(q1), .sat(q1_sat)
  );
  chi_div #(.SPAN_W(SPAN_W), .FRAC_BITS(FRAC_BITS)) u_div3 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(vb), .num(b_num3), .den(b_h),
    .out_valid(vq3), .quo(q3), .sat(q3_sat)
  );

  side1_t s1_in, s1_out;
  assign s1_in = '{sd: b_sd, e: b_e, d0: b_d0, f0: b_f0, x: b_x, h: b_h,
                   zero: b_zero, sat: b_sat};

  chi_delay #(.WIDTH($bits(side1_t)), .DEPTH(DIV_LAT)) u_dly1 (
    .clk(clk), .en(advance), .din(s1_in), .dout(s1_out)
  );

  // ---------------------------------------------------------------
  // Stage C: numerators of a (before the two /h) and b (before /h).
  // ---------------------------------------------------------------
  sres_t st, st2;
  assign st  = chi_pkg::sadd(s1_out.sd, q1);
  assign st2 = chi_pkg::ssub(q3, s1_out.e);

  logic              vc;
  acc_t              c_t, c_t2, c_d0, c_f0, c_x;
  logic [SPAN_W-1:0] c_h;
  logic              c_zero, c_sat;

  always_ff @(posedge clk) begin
    if (advance) begin
      c_t    <= st.val;
      c_t2   <= st2.val;
      c_d0   <= s1_out.d0;
      c_f0   <= s1_out.f0;
      c_x    <= s1_out.x;
      c_h    <= s1_out.h;
      c_zero <= s1_out.zero;
      c_sat  <= s1_out.sat | q1_sat | q3_sat | st.sat | st2.sat;
    end
  end

  logic vq2, vq4, q2_sat, q4_sat;
  acc_t q2, q4;

  chi_div #(.SPAN_W(SPAN_W), .FRAC_BITS(FRAC_BITS)) u_div2 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(vc), .num(c_t), .den(c_h),
    .out_valid(vq2), .quo(q2), .sat(q2_sat)
  );
  chi_div #(.SPAN_W(SPAN_W), .FRAC_BITS(FRAC_BITS)) u_div4 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(vc), .num(c_t2), .den(c_h),
    .out_valid(vq4), .quo(q4), .sat(q4_sat)
  );

  side2_t s2_in, s2_out;
  assign s2_in = '{d0: c_d0, f0: c_f0, x: c_x, h: c_h, zero: c_zero, sat: c_sat};

  chi_delay #(.WIDTH($bits(side2_t)), .DEPTH(DIV_LAT)) u_dly2 (
    .clk(clk), .en(advance), .din(s2_in), .dout(s2_out)
  );

  // Second /h for a; b (already done) waits alongside.
  logic vq5, q5_sat;
  acc_t q5;

  chi_div #(.SPAN_W(SPAN_W), .FRAC_BITS(FRAC_BITS)) u_div5 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(vq2), .num(q2), .den(s2_out.h),
    .out_valid(vq5), .quo(q5), .sat(q5_sat)
  );

  side3_t s3_in, s3_out;
  assign s3_in = '{b: q4, d0: s2_out.d0, f0: s2_out.f0, x: s2_out.x,
                   zero: s2_out.zero, sat: s2_out.sat | q2_sat | q4_sat};

  chi_delay #(.WIDTH($bits(side3_t)), .DEPTH(DIV_LAT)) u_dly3 (
    .clk(clk), .en(advance), .din(s3_in), .dout(s3_out)
  );

  // ---------------------------------------------------------------
  // Stages D and E: 3a, 2b, then 6a.
  // ---------------------------------------------------------------
  sres_t sa2, sa3, sb2, sa6;
  assign sa2 = chi_pkg::sadd(q5, q5);
  assign sa3 = chi_pkg::sadd(sa2.val, q5);
  assign sb2 = chi_pkg::sadd(s3_out.b, s3_out.b);

  logic vd;
  acc_t d_a, d_a3, d_b, d_b2, d_d0, d_f0, d_x;
  logic d_zero, d_sat;

  always_ff @(posedge clk) begin
    if (advance) begin
      d_a    <= q5;
      d_a3   <= sa3.val;
      d_b    <= s3_out.b;
      d_b2   <= sb2.val;
      d_d0   <= s3_out.d0;
      d_f0   <= s3_out.f0;
      d_x    <= s3_out.x;
      d_zero <= s3_out.zero;
      d_sat  <= s3_out.sat | q5_sat | sa2.sat | sa3.sat | sb2.sat;
    end
  end

  assign sa6 = chi_pkg::sadd(d_a3, d_a3);

  logic ve;
  acc_t e_a, e_a3, e_a6, e_b, e_b2, e_d0, e_f0, e_x;
  logic e_zero, e_sat;

  always_ff @(posedge clk) begin
    if (advance) begin
      e_a    <= d_a;
      e_a3   <= d_a3;
      e_a6   <= sa6.val;
      e_b    <= d_b;
      e_b2   <= d_b2;
      e_d0   <= d_d0;
      e_f0   <= d_f0;
      e_x    <= d_x;
      e_zero <= d_zero;
      e_sat  <= d_sat | sa6.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else if (advance) begin
      va <= request.valid;
      vb <= va;
      vc <= vq1;
      vd <= vq5;
      ve <= vd;
    end
  end

  // ---------------------------------------------------------------
  // Horner evaluation: three lanes share x; value runs three rounds deep.
  // ---------------------------------------------------------------
  logic vy1, vdy1, vdd1, y1_sat, dy1_sat, dd1_sat;
  acc_t y1, dy1, dd1;

  chi_muladd #(.FRAC_BITS(FRAC_BITS)) u_y1 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(ve), .lhs(e_a), .rhs(e_x),
    .addend(e_b), .out_valid(vy1), .res(y1), .sat(y1_sat)
  );
  chi_muladd #(.FRAC_BITS(FRAC_BITS)) u_dy1 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(ve), .lhs(e_a3), .rhs(e_x),
    .addend(e_b2), .out_valid(vdy1), .res(dy1), .sat(dy1_sat)
  );
  chi_muladd #(.FRAC_BITS(FRAC_BITS)) u_dd1 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(ve), .lhs(e_a6), .rhs(e_x),
    .addend(e_b2), .out_valid(vdd1), .res(dd1), .sat(dd1_sat)
  );

  side4_t s4_in, s4_out;
  assign s4_in = '{d0: e_d0, f0: e_f0, x: e_x, zero: e_zero, sat: e_sat};

  chi_delay #(.WIDTH($bits(side4_t)), .DEPTH(MUL_LAT)) u_dly4 (
    .clk(clk), .en(advance), .din(s4_in), .dout(s4_out)
  );

  logic vy2, vdy2, y2_sat, dy2_sat;
  acc_t y2, dy2;

  chi_muladd #(.FRAC_BITS(FRAC_BITS)) u_y2 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(vy1), .lhs(y1), .rhs(s4_out.x),
    .addend(s4_out.d0), .out_valid(vy2), .res(y2), .sat(y2_sat)
  );
  chi_muladd #(.FRAC_BITS(FRAC_BITS)) u_dy2 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(vy1), .lhs(dy1), .rhs(s4_out.x),
    .addend(s4_out.d0), .out_valid(vdy2), .res(dy2), .sat(dy2_sat)
  );

  side5_t s5_in, s5_out;
  assign s5_in = '{dd: dd1, f0: s4_out.f0, x: s4_out.x, zero: s4_out.zero,
                   sat: s4_out.sat | y1_sat | dy1_sat | dd1_sat};

  chi_delay #(.WIDTH($bits(side5_t)), .DEPTH(MUL_LAT)) u_dly5 (
    .clk(clk), .en(advance), .din(s5_in), .dout(s5_out)
  );

  logic vy3, y3_sat;
  acc_t y3;

  chi_muladd #(.FRAC_BITS(FRAC_BITS)) u_y3 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(vy2), .lhs(y2), .rhs(s5_out.x),
    .addend(s5_out.f0), .out_valid(vy3), .res(y3), .sat(y3_sat)
  );

  side6_t s6_in, s6_out;
  assign s6_in = '{dy: dy2, dd: s5_out.dd, zero: s5_out.zero,
                   sat: s5_out.sat | y2_sat | dy2_sat};

  chi_delay #(.WIDTH($bits(side6_t)), .DEPTH(MUL_LAT)) u_dly6 (
    .clk(clk), .en(advance), .din(s6_in), .dout(s6_out)
  );

  // ---------------------------------------------------------------
  // Output register: clamp to the field width, pick the status.
  // ---------------------------------------------------------------
  oclip_t cy, cdy, cdd;
  logic   sat_any;

  assign cy      = clamp_out(y3);
  assign cdy     = clamp_out(s6_out.dy);
  assign cdd     = clamp_out(s6_out.dd);
  assign sat_any = s6_out.sat | y3_sat | cy.sat | cdy.sat | cdd.sat;

  logic                  out_valid;
  logic [DATA_WIDTH-1:0] out_value, out_slope, out_curv;
  chi_pkg::status_t      out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= vy3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (s6_out.zero) begin
        // Zero span: drop the arithmetic, report zeros.
        out_value  <= '0;
        out_slope  <= '0;
        out_curv   <= '0;
        out_status <= chi_pkg::STATUS_SPAN_ZERO;
      end else begin
        out_value  <= cy.val;
        out_slope  <= cdy.val;
        out_curv   <= cdd.val;
        out_status <= sat_any ? chi_pkg::STATUS_SAT : chi_pkg::STATUS_OK;
      end
    end
  end

  assign result.valid            = out_valid;
  assign result.interp_value     = out_value;
  assign result.interp_slope     = out_slope;
  assign result.interp_curvature = out_curv;
  assign result.status           = out_status;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `CHI_ASSERT_ALWAYS(a_div_pair_first, vq1 == vq3, "first divider pair out of step")
  `CHI_ASSERT_ALWAYS(a_div_pair_second, vq2 == vq4, "second divider pair out of step")
  `CHI_ASSERT_ALWAYS(a_mul_lanes, (vy1 == vdy1) && (vy1 == vdd1) && (vy2 == vdy2),
                     "Horner lanes out of step")
  `CHI_ASSERT_IMPLY(a_span_zero_quiet,
                    result.valid && (result.status == chi_pkg::STATUS_SPAN_ZERO),
                    (result.interp_value == '0) && (result.interp_slope == '0) &&
                    (result.interp_curvature == '0),
                    "zero span with nonzero outputs")

endmodule

// ===== tb/cubic_hermite_interpolator_tb.sv =====
// Testbench for cubic_hermite_interpolator: random and corner requests, scoreboard check.
// Depends on chi_pkg, chi_ifs and the interpolator RTL.
`timescale 1ns / 1ps

module cubic_hermite_interpolator_tb;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int LATENCY = 84;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [63:0] wide_t;

  typedef struct packed {
    logic signed [DW-1:0] value_start;
    logic signed [DW-1:0] slope_start;
    logic signed [DW-1:0] value_end;
    logic signed [DW-1:0] slope_end;
    logic [DW-2:0]        span;
    logic signed [DW-1:0] position;
  } request_t;

  typedef struct packed {
    logic signed [DW-1:0] interp_value;
    logic signed [DW-1:0] interp_slope;
    logic signed [DW-1:0] interp_curvature;
    chi_pkg::status_t     status;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  chi_request_if #(.DATA_WIDTH(DW)) request ();
  chi_result_if  #(.DATA_WIDTH(DW)) result ();

  cubic_hermite_interpolator #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) uut (
    .clk(clk), .rst(rst), .request(request.sink), .result(result.source)
  );

  always #6 clk = ~clk;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int  mismatches = 0;
  longint cycles = 0;
  bit  idle_free = 1'b0;   // suppresses random idling on both sides
  bit  hold_send = 1'b0;   // pauses the sender entirely

  // ---------------- Fixed-point predictor ----------------
  // 64-bit saturating helpers; each sets sat_hit on overflow.
  bit sat_hit;

  function automatic wide_t add_sat(wide_t a, wide_t b);
    logic signed [64:0] s;
    s = a + b;
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin sat_hit = 1; return 64'sh7FFF_FFFF_FFFF_FFFF; end
    if (s < -65'sh0_8000_0000_0000_0000) begin sat_hit = 1; return {1'b1, 63'b0}; end
    return s[63:0];
  endfunction

  function automatic wide_t sub_sat(wide_t a, wide_t b);
    logic signed [64:0] s;
    s = a - b;
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin sat_hit = 1; return 64'sh7FFF_FFFF_FFFF_FFFF; end
    if (s < -65'sh0_8000_0000_0000_0000) begin sat_hit = 1; return {1'b1, 63'b0}; end
    return s[63:0];
  endfunction

  // Signed result from sign and 128-bit magnitude, clamped to 64 bits.
  function automatic wide_t clip_mag(bit neg, logic [127:0] mag);
    if (!neg) begin
      if (mag > 128'h7FFF_FFFF_FFFF_FFFF) begin sat_hit = 1; return 64'sh7FFF_FFFF_FFFF_FFFF; end
      return mag[63:0];
    end
    if (mag > 128'h8000_0000_0000_0000) begin sat_hit = 1; return {1'b1, 63'b0}; end
    return -mag[63:0];
  endfunction

  function automatic logic [63:0] abs64(wide_t v);
    return v[63] ? -v : v;
  endfunction

  // Product truncated toward zero after dropping the fraction bits.
  function automatic wide_t mul_fix(wide_t a, wide_t b);
    logic [127:0] p;
    p = {64'b0, abs64(a)} * {64'b0, abs64(b)};
    return clip_mag(a[63] != b[63], p >> FB);
  endfunction

  function automatic wide_t div_fix(wide_t n, logic [63:0] d);
    logic [127:0] q;
    q = ({64'b0, abs64(n)} << FB) / {64'b0, d};
    return clip_mag(n[63], q);
  endfunction

  function automatic logic signed [DW-1:0] narrow(wide_t v);
    if (v > 64'sd2147483647) begin sat_hit = 1; return 32'sh7FFF_FFFF; end
    if (v < -64'sd2147483648) begin sat_hit = 1; return 32'sh8000_0000; end
    return v[DW-1:0];
  endfunction

  function automatic answer_t hermite_eval(request_t rq);
    wide_t f0, d0, f1, d1, x, t, a, b, a3, a6, b2, y, dy, ddy;
    logic [63:0] h;
    answer_t ans;
    f0 = rq.value_start; d0 = rq.slope_start;
    f1 = rq.value_end;   d1 = rq.slope_end;
    x  = rq.position;    h  = {33'b0, rq.span};
    sat_hit = 0;
    if (h == 0) begin
      ans.interp_value = '0; ans.interp_slope = '0; ans.interp_curvature = '0;
      ans.status = chi_pkg::STATUS_SPAN_ZERO;
      return ans;
    end
    t = sub_sat(f0, f1);
    t = div_fix(add_sat(t, t), h);
    t = add_sat(add_sat(d0, d1), t);
    a = div_fix(div_fix(t, h), h);
    t = sub_sat(f1, f0);
    t = div_fix(add_sat(add_sat(t, t), t), h);
    t = sub_sat(t, add_sat(d1, add_sat(d0, d0)));
    b = div_fix(t, h);
    y = add_sat(mul_fix(a, x), b);
    y = add_sat(mul_fix(y, x), d0);
    y = add_sat(mul_fix(y, x), f0);
    a3 = add_sat(add_sat(a, a), a);
    a6 = add_sat(a3, a3);
    b2 = add_sat(b, b);
    dy = add_sat(mul_fix(a3, x), b2);
    dy = add_sat(mul_fix(dy, x), d0);
    ddy = add_sat(mul_fix(a6, x), b2);
    ans.interp_value = narrow(y);
    ans.interp_slope = narrow(dy);
    ans.interp_curvature = narrow(ddy);
    ans.status = sat_hit ? chi_pkg::STATUS_SAT : chi_pkg::STATUS_OK;
    return ans;
  endfunction

  // ---------------- Driver ----------------
  // Offer the head of the queue; advance once the block takes it.
  initial begin
    request.valid = 1'b0;
    {request.value_start, request.slope_start, request.value_end,
     request.slope_end, request.span, request.position} = '0;
    result.ready = 1'b0;
  end

  always @(posedge clk) begin
    bit waiting;
    waiting = request.valid && !request.ready;
    if (!rst) begin
      if (request.valid && request.ready) begin
        expected_answers.push_back(hermite_eval(pending_requests.pop_front()));
      end
      // Hold an offered request unchanged until the block takes it.
      if (!waiting) begin
        if (pending_requests.size() > 0 && !hold_send &&
            (idle_free || $urandom_range(99) >= 27)) begin
          request.valid       <= 1'b1;
          request.value_start <= pending_requests[0].value_start;
          request.slope_start <= pending_requests[0].slope_start;
          request.value_end   <= pending_requests[0].value_end;
          request.slope_end   <= pending_requests[0].slope_end;
          request.span        <= pending_requests[0].span;
          request.position    <= pending_requests[0].position;
        end else begin
          request.valid <= 1'b0;
        end
      end
    end
  end

  // The queue head may only change after acceptance, so the popped entry is what was driven:
  // a new head is offered only after the pop above, on the same edge.

  // ---------------- Monitor ----------------
  always @(posedge clk) begin
    answer_t got, want;
    if (!rst) begin
      cycles <= cycles + 1;
      if (result.valid && result.ready) begin
        got = {result.interp_value, result.interp_slope, result.interp_curvature,
               chi_pkg::status_t'(result.status)};
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_answers.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: value exp %h got %h, slope exp %h got %h, ",
                        "curv exp %h got %h, status exp %0d got %0d"},
                       want.interp_value, got.interp_value, want.interp_slope,
                       got.interp_slope, want.interp_curvature, got.interp_curvature,
                       want.status, got.status);
          end
        end
      end
      result.ready <= idle_free || ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("cubic_hermite_interpolator_tb: done, errors");
      $finish;
    end
  end

  // ---------------- Stimulus ----------------
  function automatic logic signed [DW-1:0] rnd_field();
    case ($urandom_range(5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-scaled curves with x inside the interval, so outputs do not saturate.
  function automatic request_t rnd_request();
    request_t rq;
    logic [DW-2:0] h;
    if ($urandom_range(99) < 70) begin
      h = 31'($urandom_range(32'h0000_4000, 32'h0010_0000));
      rq.value_start = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      rq.value_end   = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      rq.slope_start = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      rq.slope_end   = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      rq.span        = h;
      rq.position    = $urandom_range(0, h);
    end else begin
      rq.value_start = rnd_field(); rq.slope_start = rnd_field();
      rq.value_end = rnd_field();   rq.slope_end = rnd_field();
      case ($urandom_range(3))
        0: rq.span = '0;
        1: rq.span = '1;
        2: rq.span = 31'($urandom_range(1, 4));
        default: rq.span = 31'($urandom);
      endcase
      rq.position = rnd_field();
    end
    return rq;
  endfunction

  function automatic request_t make_req(logic signed [DW-1:0] f0, d0, f1, d1,
                                        logic [DW-2:0] h, logic signed [DW-1:0] x);
    request_t rq;
    rq = {f0, d0, f1, d1, h, x};
    return rq;
  endfunction

  task automatic wait_drained();
    while (pending_requests.size() > 0 || expected_answers.size() > 0 || request.valid)
      @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero span, field extremes, unit curve, saturation.
    pending_requests.push_back(make_req(32'sh0001_0000, 0, 32'sh0002_0000, 0, '0, 32'sh0000_8000));
    pending_requests.push_back(make_req('1, '1, '1, '1, '0, '1));
    pending_requests.push_back(make_req(0, 0, 32'sh0001_0000, 0, 31'h0001_0000, 32'sh0000_8000));
    pending_requests.push_back(make_req(0, 32'sh0001_0000, 32'sh0001_0000,
                                        32'sh0001_0000, 31'h0001_0000, 32'sh0000_4000));
    pending_requests.push_back(make_req(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                        32'sh8000_0000, 31'd1, 32'sh7FFF_FFFF));
    pending_requests.push_back(make_req(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                        32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000));
    pending_requests.push_back(make_req(0, 0, 0, 0, 31'h7FFF_FFFF, 0));
    pending_requests.push_back(make_req(32'sh0005_0000, 32'shFFFF_0000, 32'shFFFD_0000,
                                        32'sh0002_0000, 31'h0004_0000, 32'sh0004_0000));
    pending_requests.push_back(make_req(32'sh0005_0000, 32'shFFFF_0000, 32'shFFFD_0000,
                                        32'sh0002_0000, 31'h0004_0000, 32'shFFFF_0000));
    pending_requests.push_back(make_req(32'sh0000_0001, 32'shFFFF_FFFF, 32'sh5555_AAAA,
                                        32'shAAAA_5555, 31'h2AAA_5555, 32'sh5555_AAAA));
    pending_requests.push_back(make_req(32'shFFFF_FFFE, 32'sh0000_0002, 32'shAAAA_5555,
                                        32'sh5555_AAAA, 31'h5555_2AAA, 32'shAAAA_5555));
    wait_drained();

    // Start a batch, pause the sender until every result is back, then finish it
    // as a burst with no idling.
    repeat (100) pending_requests.push_back(rnd_request());
    repeat (40) @(posedge clk);
    hold_send = 1'b1;
    while (expected_answers.size() > 0 || request.valid)
      @(posedge clk);
    hold_send = 1'b0;
    idle_free = 1'b1;
    wait_drained();
    idle_free = 1'b0;

    repeat (1200) pending_requests.push_back(rnd_request());
    wait_drained();
    repeat (LATENCY * 2) @(posedge clk);

    if (mismatches == 0 && expected_answers.size() == 0)
      $display("cubic_hermite_interpolator_tb: done, clean");
    else
      $display("cubic_hermite_interpolator_tb: done, errors");
    $finish;
  end
endmodule
